// File: rtl/slq_pkg.sv
// package for the sparkline level quantizer
// types and fixed constants shared by the rtl; depends on nothing
`default_nettype none
package slq_pkg;

   localparam int SAMPLE_W = 32;
   localparam int STORED_W = 31;
   localparam int LEVEL_W  = 3;
   localparam int GLYPH_W  = 24;
   localparam int CSR_W    = 7;

   typedef logic [STORED_W-1:0] stored_type;
   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [GLYPH_W-1:0]  glyph_type;
   typedef logic [CSR_W-1:0]    csr_type;

   localparam glyph_type GLYPH_BASE  = 24'hE29681;
   localparam glyph_type GLYPH_SPACE = 24'h000020;
   localparam level_type FLAT_LEVEL  = 3'd3;
   localparam csr_type   WIDTH_RESET = 7'd32;

endpackage
`default_nettype wire

// File: rtl/slq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module slq_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/sparkline_level_quantizer_unit.sv
// top level of the sparkline level quantizer: sample ring, min/max scan,
// level divider and column output; uses slq_pkg and slq_ram
`default_nettype none
// Samples (signed Q16.16, negatives clamped to zero) are written to a ring
// memory of MAX_COLUMNS entries, one transfer per cycle while the block is idle.
// A sample with series_end set starts a render: the newest min(fill, width)
// samples are read back oldest first, once to find min and max (one ring
// read per cycle) and once more to emit columns. Each sample column passes
// through a ring read, difference times seven, three restoring division steps
// (skipped when all samples are equal) and an output load; pad columns need
// only the output load. Both output loads wait while the result side stalls.
// req_stall is high for the whole render. width is display_width saturated to
// MAX_COLUMNS; a width of zero renders nothing but still clears the fill count.
module sparkline_level_quantizer_unit #(
   parameter int MAX_COLUMNS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_sample_value,
   input  wire logic        req_series_end,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_bar_level,
   output logic             rsp_is_padding,
   output logic [23:0]      rsp_glyph_utf8,
   output logic             rsp_last_column,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data
);

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CW = $clog2(MAX_COLUMNS + 1);
   localparam int FW = CW + 1;
   localparam int RW = slq_pkg::STORED_W + 3;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_COL_RD = 3'd2;
   localparam logic [2:0] S_SUB    = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;
   localparam logic [2:0] S_PAD    = 3'd6;

   // control state
   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic [CW-1:0]         fill_ff, fill_in;
   slq_pkg::csr_type      dwidth_ff, dwidth_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         width_ff, width_in;
   logic [AW-1:0]         first_ff, first_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [CW-1:0]         iss_ff, iss_in;
   logic                  rdv_ff, rdv_in;
   logic                  seen_ff, seen_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [1:0]            step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // datapath registers
   slq_pkg::stored_type   min_ff, min_in;
   slq_pkg::stored_type   max_ff, max_in;
   slq_pkg::stored_type   range_ff, range_in;
   logic                  flat_ff, flat_in;
   logic [RW-1:0]         rem_ff, rem_in;
   slq_pkg::level_type    q_ff, q_in;
   slq_pkg::level_type    lvl_ff, lvl_in;
   logic                  pad_ff, pad_in;
   slq_pkg::glyph_type    glyph_ff, glyph_in;
   logic                  last_ff, last_in;

   // ring memory port signals
   logic                  ram_wr_en;
   slq_pkg::stored_type   ram_wr_data;
   logic                  ram_rd_en;
   slq_pkg::stored_type   ram_rd_data;

   // helpers
   logic                  in_xfer;
   logic                  out_free;
   logic [AW-1:0]         wp_next;
   logic [AW-1:0]         addr_next;
   logic [CW-1:0]         fill_next;
   logic [CW-1:0]         width_sat;
   logic [CW-1:0]         count_now;
   logic [FW-1:0]         first_sum;
   slq_pkg::stored_type   diff;
   logic [RW-1:0]         trial_div;
   logic [RW-1:0]         trial_rem;
   logic                  col_is_last;
   slq_pkg::level_type    emit_level;

   slq_ram #(
      .WIDTH (slq_pkg::STORED_W),
      .DEPTH (MAX_COLUMNS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign in_xfer   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // negative samples clamp to zero, sign bit dropped
   assign ram_wr_en   = in_xfer;
   assign ram_wr_data = req_sample_value[31] ? '0 : req_sample_value[30:0];

   // ring pointer and scan address wrap at the ring depth
   assign wp_next   = (wp_ff == AW'(MAX_COLUMNS - 1)) ? '0 : wp_ff + 1'b1;
   assign addr_next = (addr_ff == AW'(MAX_COLUMNS - 1)) ? '0 : addr_ff + 1'b1;

   assign fill_next = (fill_ff < CW'(MAX_COLUMNS)) ? fill_ff + 1'b1 : fill_ff;
   assign width_sat = ({25'd0, dwidth_ff} > 32'(MAX_COLUMNS)) ?
                      CW'(MAX_COLUMNS) : CW'(dwidth_ff);
   assign count_now = (fill_next < width_sat) ? fill_next : width_sat;

   // oldest kept slot: pointer after this write minus count, modulo depth
   always_comb begin
      first_sum = FW'(wp_next) + FW'(MAX_COLUMNS) - FW'(count_now);
      if (first_sum >= FW'(MAX_COLUMNS)) begin
         first_sum = first_sum - FW'(MAX_COLUMNS);
      end
   end

   assign diff = ram_rd_data - min_ff;

   // restoring division step: quotient bit worth 4, 2, then 1 times range
   always_comb begin
      case (step_ff)
         2'd0:    trial_div = {1'b0, range_ff, 2'b00};
         2'd1:    trial_div = {2'b00, range_ff, 1'b0};
         default: trial_div = {3'b000, range_ff};
      endcase
      trial_rem = rem_ff - trial_div;
   end

   assign col_is_last = ((col_ff + 1'b1) == width_ff);
   assign emit_level  = flat_ff ? slq_pkg::FLAT_LEVEL : q_ff;

   // read enable: issue during the scan and once per sample column
   assign ram_rd_en = ((state_ff == S_SCAN) && (iss_ff < count_ff)) ||
                      (state_ff == S_COL_RD);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      dwidth_in    = dwidth_ff;
      count_in     = count_ff;
      width_in     = width_ff;
      first_in     = first_ff;
      addr_in      = addr_ff;
      iss_in       = iss_ff;
      rdv_in       = 1'b0;
      seen_in      = seen_ff;
      col_in       = col_ff;
      step_in      = step_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      range_in     = range_ff;
      flat_in      = flat_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      lvl_in       = lvl_ff;
      pad_in       = pad_ff;
      glyph_in     = glyph_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         dwidth_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (in_xfer) begin
               wp_in   = wp_next;
               fill_in = fill_next;
               if (req_series_end) begin
                  fill_in  = '0;
                  count_in = count_now;
                  width_in = width_sat;
                  first_in = AW'(first_sum);
                  addr_in  = AW'(first_sum);
                  iss_in   = '0;
                  seen_in  = 1'b0;
                  col_in   = '0;
                  if (width_sat != '0) begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (iss_ff < count_ff) begin
               iss_in  = iss_ff + 1'b1;
               addr_in = addr_next;
               rdv_in  = 1'b1;
            end
            if (rdv_ff) begin
               seen_in = 1'b1;
               if (!seen_ff || (ram_rd_data < min_ff)) begin
                  min_in = ram_rd_data;
               end
               if (!seen_ff || (ram_rd_data > max_ff)) begin
                  max_in = ram_rd_data;
               end
               if (iss_ff == count_ff) begin
                  addr_in  = first_ff;
                  state_in = S_COL_RD;
               end
            end
         end
         S_COL_RD: begin
            range_in = max_ff - min_ff;
            flat_in  = (max_ff == min_ff);
            addr_in  = addr_next;
            state_in = S_SUB;
         end
         S_SUB: begin
            // seven times the offset from the minimum
            rem_in  = {diff, 3'b000} - RW'(diff);
            q_in    = '0;
            step_in = '0;
            state_in = flat_ff ? S_EMIT : S_DIV;
         end
         S_DIV: begin
            if (!trial_rem[RW-1] && (rem_ff >= trial_div)) begin
               rem_in = trial_rem;
               q_in   = {q_ff[1:0], 1'b1};
            end else begin
               q_in   = {q_ff[1:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd2) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               lvl_in       = emit_level;
               pad_in       = 1'b0;
               glyph_in     = slq_pkg::GLYPH_BASE + slq_pkg::glyph_type'(emit_level);
               last_in      = col_is_last;
               col_in       = col_ff + 1'b1;
               if (col_is_last) begin
                  state_in = S_IDLE;
               end else if ((col_ff + 1'b1) == count_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_COL_RD;
               end
            end
         end
         S_PAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               lvl_in       = '0;
               pad_in       = 1'b1;
               glyph_in     = slq_pkg::GLYPH_SPACE;
               last_in      = col_is_last;
               col_in       = col_ff + 1'b1;
               if (col_is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         dwidth_ff    <= slq_pkg::WIDTH_RESET;
         count_ff     <= '0;
         width_ff     <= '0;
         first_ff     <= '0;
         addr_ff      <= '0;
         iss_ff       <= '0;
         rdv_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         col_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         dwidth_ff    <= dwidth_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
         first_ff     <= first_in;
         addr_ff      <= addr_in;
         iss_ff       <= iss_in;
         rdv_ff       <= rdv_in;
         seen_ff      <= seen_in;
         col_ff       <= col_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      min_ff   <= min_in;
      max_ff   <= max_in;
      range_ff <= range_in;
      flat_ff  <= flat_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      lvl_ff   <= lvl_in;
      pad_ff   <= pad_in;
      glyph_ff <= glyph_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bar_level   = lvl_ff;
   assign rsp_is_padding  = pad_ff;
   assign rsp_glyph_utf8  = glyph_ff;
   assign rsp_last_column = last_ff;

endmodule
`default_nettype wire
